// ===== sv/dllm_pkg.sv =====
package dllm_pkg;

	localparam int NODES_DEF      = 256;
	localparam int LISTS_DEF      = 4;
	localparam int VALUE_BITS_DEF = 32;

	localparam logic [3:0] F_ADD_FIRST = 4'd0;
	localparam logic [3:0] F_ADD_LAST  = 4'd1;
	localparam logic [3:0] F_ADD_AFTER = 4'd2;
	localparam logic [3:0] F_FIRST     = 4'd3;
	localparam logic [3:0] F_LAST      = 4'd4;
	localparam logic [3:0] F_NEXT      = 4'd5;
	localparam logic [3:0] F_PREV      = 4'd6;
	localparam logic [3:0] F_UNLINK    = 4'd7;
	localparam logic [3:0] F_CLEAR     = 4'd8;

	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_LINKED = 2'd1;
	localparam logic [1:0] ST_BADREF = 2'd2;

	typedef enum logic [1:0] {
		ALU_PASS = 2'd0,
		ALU_INC  = 2'd1,
		ALU_DEC  = 2'd2
	} alu_op_t;

	typedef enum logic [9:0] {
		S_INIT = 10'b00_0000_0001,
		S_IDLE = 10'b00_0000_0010,
		S_CHK  = 10'b00_0000_0100,
		S_OWN  = 10'b00_0000_1000,
		S_REF  = 10'b00_0001_0000,
		S_INS  = 10'b00_0010_0000,
		S_INS2 = 10'b00_0100_0000,
		S_UNL  = 10'b00_1000_0000,
		S_CLR  = 10'b01_0000_0000,
		S_VAL  = 10'b10_0000_0000
	} state_t;

endpackage

// ===== sv/dllm_ram.sv =====
module dllm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== sv/dllm_alu.sv =====
module dllm_alu import dllm_pkg::*; #(
	parameter int CNT_W = 9
) (
	input  alu_op_t          op,
	input  logic [CNT_W-1:0] operand,
	output logic [CNT_W-1:0] result
);

	always_comb begin
		case (op)
			ALU_INC: begin
				result = operand + CNT_W'(1);
			end
			ALU_DEC: begin
				result = (operand == '0) ? '0 : operand - CNT_W'(1);
			end
			default: begin
				result = operand;
			end
		endcase
	end

endmodule

// ===== sv/doubly_linked_list_manager_unit.sv =====
// Channel   Direction  Handshake       Fields
// request   in         start & !busy   func, list_id, node_index, after_index, payload
// result    out        done (1 cycle)  found_valid, found_index, found_value, list_count, status
//
// Each request is served through the registered reads and the single write port of
// each link memory; clear unlinks its list node by node. A rejected request or an
// unused code ends early. The result strobe is high in the first cycle with busy low.
// After reset an owner clearing pass over every node holds busy high.
// The receiver cannot stall: done is high for one cycle only; the result fields hold until the next result.
module doubly_linked_list_manager_unit import dllm_pkg::*; #(
	parameter int NODES      = NODES_DEF,
	parameter int LISTS      = LISTS_DEF,
	parameter int VALUE_BITS = VALUE_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [3:0]  func,
	input  logic [1:0]  list_id,
	input  logic [7:0]  node_index,
	input  logic [7:0]  after_index,
	input  logic [31:0] payload,
	output logic        done,
	output logic        found_valid,
	output logic [7:0]  found_index,
	output logic [31:0] found_value,
	output logic [8:0]  list_count,
	output logic [1:0]  status
);

	localparam int NODE_W = $clog2(NODES);
	localparam int LIST_W = (LISTS > 1) ? $clog2(LISTS) : 1;
	localparam int OWN_W  = $clog2(LISTS + 1);
	localparam int LINK_W = $clog2(NODES + LISTS);
	localparam int CNT_W  = $clog2(NODES + 1);

	state_t state_q, state_d;

	logic [3:0]            func_q;
	logic                  l_bad_q, n_bad_q, a_bad_q;
	logic [LIST_W-1:0]     lst_q, lst_d;
	logic [NODE_W-1:0]     n_q, n_d, a_q, clr_q;
	logic [VALUE_BITS-1:0] v_q;
	logic [LINK_W-1:0]     r_q, r_d, nn_q, nn_d, pp_q, pp_d;

	logic [LINK_W-1:0] head_q [LISTS];
	logic [LINK_W-1:0] tail_q [LISTS];
	logic [CNT_W-1:0]  count_q [LISTS];

	logic [LINK_W-1:0] head_sel, tail_sel, sent_link, n_link, ref_link;
	logic [CNT_W-1:0]  cnt_sel, alu_res;
	logic [OWN_W-1:0]  own_lst;
	logic              r_node, nn_node, pp_node, need_list, accept;
	alu_op_t           alu_op;

	logic                  own_we, nxt_we, prv_we, val_we;
	logic [NODE_W-1:0]     own_wa, nxt_wa, prv_wa, own_ra, nxt_ra, prv_ra, val_ra;
	logic [OWN_W-1:0]      own_wd, own_rd;
	logic [LINK_W-1:0]     nxt_wd, prv_wd, nxt_rd, prv_rd;
	logic [VALUE_BITS-1:0] val_rd;

	logic        fin, fin_fv;
	logic [7:0]  fin_fi;
	logic [31:0] fin_fval;
	logic [8:0]  fin_cnt;
	logic [1:0]  fin_st;

	logic        done_q, fv_q;
	logic [7:0]  fi_q;
	logic [31:0] fval_q;
	logic [8:0]  cnt_q;
	logic [1:0]  st_q;

	assign busy   = (state_q != S_IDLE);
	assign accept = start && !busy;

	assign head_sel  = head_q[lst_q];
	assign tail_sel  = tail_q[lst_q];
	assign cnt_sel   = count_q[lst_q];
	assign sent_link = LINK_W'(NODES) + LINK_W'(lst_q);
	assign n_link    = LINK_W'(n_q);
	assign own_lst   = OWN_W'(lst_q) + OWN_W'(1);
	assign r_node    = r_q < LINK_W'(NODES);
	assign nn_node   = nn_q < LINK_W'(NODES);
	assign pp_node   = pp_q < LINK_W'(NODES);
	assign need_list = (func_q <= F_LAST) || (func_q == F_CLEAR);
	assign ref_link  = (func_q == F_NEXT) ? nxt_rd : prv_rd;

	// count unit, shared by every add and unlink
	assign alu_op = (state_q == S_INS2) ? ALU_INC :
			(state_q == S_UNL) ? ALU_DEC : ALU_PASS;

	dllm_alu #(.CNT_W(CNT_W)) u_alu (
		.op      (alu_op),
		.operand (cnt_sel),
		.result  (alu_res)
	);

	// read addresses
	assign own_ra = (state_q == S_OWN) ? a_q : n_q;
	assign nxt_ra = (state_q == S_CLR) ? NODE_W'(head_sel) :
			(func_q == F_ADD_AFTER) ? a_q : n_q;
	assign prv_ra = (state_q == S_CLR) ? NODE_W'(head_sel) : n_q;

	always_comb begin
		case (state_q)
			S_CHK:   val_ra = NODE_W'((func_q == F_FIRST) ? head_sel : tail_sel);
			S_OWN:   val_ra = NODE_W'(ref_link);
			default: val_ra = n_q;
		endcase
	end

	// write ports
	always_comb begin
		own_we = 1'b0;
		own_wa = n_q;
		own_wd = '0;
		nxt_we = 1'b0;
		nxt_wa = n_q;
		nxt_wd = nn_q;
		prv_we = 1'b0;
		prv_wa = n_q;
		prv_wd = r_q;
		val_we = 1'b0;
		case (state_q)
			S_INIT: begin
				own_we = 1'b1;
				own_wa = clr_q;
			end
			S_INS: begin
				own_we = 1'b1;
				own_wd = own_lst;
				nxt_we = 1'b1;
				prv_we = 1'b1;
				val_we = 1'b1;
			end
			S_INS2: begin
				nxt_we = r_node;
				nxt_wa = NODE_W'(r_q);
				nxt_wd = n_link;
				prv_we = nn_node;
				prv_wa = NODE_W'(nn_q);
				prv_wd = n_link;
			end
			S_UNL: begin
				own_we = 1'b1;
				nxt_we = pp_node;
				nxt_wa = NODE_W'(pp_q);
				nxt_wd = nn_q;
				prv_we = nn_node;
				prv_wa = NODE_W'(nn_q);
				prv_wd = pp_q;
			end
			default: begin
			end
		endcase
	end

	dllm_ram #(.WIDTH(OWN_W), .DEPTH(NODES)) u_owner_ram (
		.clk   (clk),
		.we    (own_we),
		.waddr (own_wa),
		.wdata (own_wd),
		.raddr (own_ra),
		.rdata (own_rd)
	);

	dllm_ram #(.WIDTH(LINK_W), .DEPTH(NODES)) u_next_ram (
		.clk   (clk),
		.we    (nxt_we),
		.waddr (nxt_wa),
		.wdata (nxt_wd),
		.raddr (nxt_ra),
		.rdata (nxt_rd)
	);

	dllm_ram #(.WIDTH(LINK_W), .DEPTH(NODES)) u_prev_ram (
		.clk   (clk),
		.we    (prv_we),
		.waddr (prv_wa),
		.wdata (prv_wd),
		.raddr (prv_ra),
		.rdata (prv_rd)
	);

	dllm_ram #(.WIDTH(VALUE_BITS), .DEPTH(NODES)) u_value_ram (
		.clk   (clk),
		.we    (val_we),
		.waddr (n_q),
		.wdata (v_q),
		.raddr (val_ra),
		.rdata (val_rd)
	);

	// sequencer
	always_comb begin
		state_d  = state_q;
		lst_d    = lst_q;
		n_d      = n_q;
		r_d      = r_q;
		nn_d     = nn_q;
		pp_d     = pp_q;
		fin      = 1'b0;
		fin_fv   = 1'b0;
		fin_fi   = '0;
		fin_fval = '0;
		fin_cnt  = '0;
		fin_st   = ST_OK;
		case (state_q)
			S_INIT: begin
				if (clr_q == NODE_W'(NODES - 1)) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (start) begin
					lst_d   = LIST_W'(list_id);
					n_d     = NODE_W'(node_index);
					state_d = S_CHK;
				end
			end
			S_CHK: begin
				state_d = S_IDLE;
				if (need_list && l_bad_q) begin
					fin    = 1'b1;
					fin_st = ST_BADREF;
				end else begin
					case (func_q)
						F_ADD_FIRST, F_ADD_LAST, F_ADD_AFTER: begin
							if (n_bad_q) begin
								fin     = 1'b1;
								fin_st  = ST_BADREF;
								fin_cnt = 9'(cnt_sel);
							end else begin
								state_d = S_OWN;
							end
						end
						F_FIRST, F_LAST: begin
							r_d     = (func_q == F_FIRST) ? head_sel : tail_sel;
							state_d = S_VAL;
						end
						F_NEXT, F_PREV, F_UNLINK: begin
							if (n_bad_q) begin
								fin    = 1'b1;
								fin_st = ST_BADREF;
							end else begin
								state_d = S_OWN;
							end
						end
						F_CLEAR: begin
							state_d = S_CLR;
						end
						default: begin
							fin = 1'b1;
						end
					endcase
				end
			end
			S_OWN: begin
				state_d = S_IDLE;
				case (func_q)
					F_ADD_FIRST, F_ADD_LAST, F_ADD_AFTER: begin
						if (own_rd != '0) begin
							fin     = 1'b1;
							fin_st  = ST_LINKED;
							fin_cnt = 9'(cnt_sel);
						end else if (func_q == F_ADD_AFTER) begin
							if (a_bad_q) begin
								fin     = 1'b1;
								fin_st  = ST_BADREF;
								fin_cnt = 9'(cnt_sel);
							end else begin
								nn_d    = nxt_rd;
								state_d = S_REF;
							end
						end else begin
							r_d     = (func_q == F_ADD_FIRST) ? sent_link : tail_sel;
							nn_d    = (func_q == F_ADD_FIRST) ? head_sel : sent_link;
							state_d = S_INS;
						end
					end
					F_NEXT, F_PREV: begin
						if (own_rd == '0) begin
							fin    = 1'b1;
							fin_st = ST_BADREF;
						end else begin
							lst_d   = LIST_W'(own_rd - OWN_W'(1));
							r_d     = ref_link;
							state_d = S_VAL;
						end
					end
					F_UNLINK: begin
						if (own_rd == '0) begin
							fin = 1'b1;
						end else begin
							lst_d   = LIST_W'(own_rd - OWN_W'(1));
							nn_d    = nxt_rd;
							pp_d    = prv_rd;
							state_d = S_UNL;
						end
					end
					F_CLEAR: begin
						nn_d    = nxt_rd;
						pp_d    = prv_rd;
						state_d = S_UNL;
					end
					default: begin
						fin = 1'b1;
					end
				endcase
			end
			S_REF: begin
				if (own_rd != own_lst) begin
					fin     = 1'b1;
					fin_st  = ST_BADREF;
					fin_cnt = 9'(cnt_sel);
					state_d = S_IDLE;
				end else begin
					r_d     = LINK_W'(a_q);
					state_d = S_INS;
				end
			end
			S_INS: begin
				state_d = S_INS2;
			end
			S_INS2: begin
				fin     = 1'b1;
				fin_cnt = 9'(alu_res);
				state_d = S_IDLE;
			end
			S_UNL: begin
				if (func_q == F_CLEAR) begin
					state_d = S_CLR;
				end else begin
					fin     = 1'b1;
					fin_cnt = 9'(alu_res);
					state_d = S_IDLE;
				end
			end
			S_CLR: begin
				if (head_sel < LINK_W'(NODES)) begin
					n_d     = NODE_W'(head_sel);
					state_d = S_OWN;
				end else begin
					fin     = 1'b1;
					fin_cnt = 9'(cnt_sel);
					state_d = S_IDLE;
				end
			end
			S_VAL: begin
				fin     = 1'b1;
				fin_cnt = 9'(cnt_sel);
				if (r_node) begin
					fin_fv   = 1'b1;
					fin_fi   = 8'(r_q);
					fin_fval = 32'(val_rd);
				end
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
			clr_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= fin;
			if (state_q == S_INIT) begin
				clr_q <= clr_q + NODE_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		lst_q <= lst_d;
		n_q   <= n_d;
		r_q   <= r_d;
		nn_q  <= nn_d;
		pp_q  <= pp_d;
		if (accept) begin
			func_q  <= func;
			a_q     <= NODE_W'(after_index);
			v_q     <= VALUE_BITS'(payload);
			l_bad_q <= {30'd0, list_id} >= 32'(LISTS);
			n_bad_q <= {24'd0, node_index} >= 32'(NODES);
			a_bad_q <= {24'd0, after_index} >= 32'(NODES);
		end
		if (fin) begin
			fv_q   <= fin_fv;
			fi_q   <= fin_fi;
			fval_q <= fin_fval;
			cnt_q  <= fin_cnt;
			st_q   <= fin_st;
		end
	end

	// sentinels
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int l = 0; l < LISTS; l++) begin
				head_q[l]  <= LINK_W'(NODES + l);
				tail_q[l]  <= LINK_W'(NODES + l);
				count_q[l] <= '0;
			end
		end else begin
			if (state_q == S_INS2) begin
				if (!r_node) begin
					head_q[lst_q] <= n_link;
				end
				if (!nn_node) begin
					tail_q[lst_q] <= n_link;
				end
				count_q[lst_q] <= alu_res;
			end
			if (state_q == S_UNL) begin
				if (!pp_node) begin
					head_q[lst_q] <= nn_q;
				end
				if (!nn_node) begin
					tail_q[lst_q] <= pp_q;
				end
				count_q[lst_q] <= alu_res;
			end
		end
	end

	assign done        = done_q;
	assign found_valid = fv_q;
	assign found_index = fi_q;
	assign found_value = fval_q;
	assign list_count  = cnt_q;
	assign status      = st_q;

endmodule
